FILE: hdl/scalar_kalman_filter_core_defines.svh
// Assertion macros shared by the scalar Kalman filter RTL.
`ifndef SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SKF_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SKF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/skf_pkg.sv
// Shared widths, constants and beat types of the scalar Kalman filter.
package skf_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int CFG_WIDTH  = 32;
  localparam int CFG_IDX_W  = 1;

  // Width that holds variance plus a noise register without overflow.
  localparam int WIDE_W = ((DATA_WIDTH > CFG_WIDTH) ? DATA_WIDTH : CFG_WIDTH) + 1;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 1'b1;

  localparam logic [CFG_WIDTH-1:0] NOISE_RESET = CFG_WIDTH'(65536);

  // One in the data format, masked to the data width.
  localparam logic [DATA_WIDTH-1:0] ONE_DATA = DATA_WIDTH'(1) << FRAC_BITS;
  // One in the gain format Q1.FRAC_BITS.
  localparam logic [FRAC_BITS:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic                         mode;
    logic signed [DATA_WIDTH-1:0] measurement;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] estimate;
    logic        [FRAC_BITS:0]    gain;
  } out_beat_t;

endpackage

FILE: hdl/skf_div.sv
// Restoring divider giving floor(num * 2^FRAC_BITS / den), one quotient bit per cycle.
module skf_div #(
  parameter int NUM_W     = skf_pkg::DATA_WIDTH,
  parameter int DEN_W     = skf_pkg::WIDE_W,
  parameter int FRAC_BITS = skf_pkg::FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NUM_W-1:0]   num_i,
  input  logic [DEN_W-1:0]   den_i,
  output logic               done_o,
  output logic [FRAC_BITS:0] quo_o
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic               busy_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DEN_W:0]     rem_q;
  logic [DEN_W-1:0]   den_q;
  logic [FRAC_BITS:0] quo_q;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] den_ext;
  logic           fits;
  logic [DEN_W:0] rem_d;
  logic           last;

  // The integer bit is tried without a shift, every later bit after one.
  assign trial   = (cnt_q == '0) ? rem_q : {rem_q[DEN_W-1:0], 1'b0};
  assign den_ext = {1'b0, den_q};
  assign fits    = trial >= den_ext;
  assign rem_d   = fits ? (trial - den_ext) : trial;
  assign last    = cnt_q == CNT_W'(FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (den_i == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= (DEN_W+1)'(num_i);
      // A zero divisor gives a gain of exactly one.
      quo_q <= (den_i == '0) ? {1'b1, {FRAC_BITS{1'b0}}} : '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[FRAC_BITS-1:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: hdl/skf_mul.sv
// Bit-serial multiplier giving floor(mag * k / 2^FRAC_BITS) for k up to one.
module skf_mul #(
  parameter int MAG_W     = skf_pkg::DATA_WIDTH + 1,
  parameter int FRAC_BITS = skf_pkg::FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MAG_W-1:0]   mag_i,
  input  logic [FRAC_BITS:0] k_i,
  output logic               done_o,
  output logic [MAG_W-1:0]   prod_o
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic               busy_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [MAG_W-1:0]   mag_q;
  logic [FRAC_BITS:0] k_q;
  logic [MAG_W-1:0]   acc_q;

  logic [MAG_W:0] sum;
  logic           last;

  assign sum  = {1'b0, acc_q} + (k_q[0] ? {1'b0, mag_q} : '0);
  assign last = cnt_q == CNT_W'(FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Fractional weights shift the partial sum right and drop the low bit;
  // the integer weight of k is added in place on the final step.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= mag_i;
      k_q   <= k_i;
      acc_q <= '0;
    end else if (busy_q) begin
      k_q   <= k_q >> 1;
      acc_q <= last ? sum[MAG_W-1:0] : sum[MAG_W:1];
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

FILE: hdl/scalar_kalman_filter_core.sv
// Top level of the scalar Kalman filter: one measurement beat in, one estimate beat out.
// A measurement beat goes through prediction, the serial divider and then the two serial
// multipliers, which run in parallel; a zero gain divisor ends the division without its
// serial steps. A restart beat skips to the result. A held result stalls the next beat.
// No new beat is taken until the last result has moved into the output register.
// Reset: estimate and variance return to one, both noise registers to one, no beat held.
`include "scalar_kalman_filter_core_defines.svh"

module scalar_kalman_filter_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  skf_pkg::in_beat_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output skf_pkg::out_beat_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [skf_pkg::CFG_IDX_W-1:0]       cfg_addr_i,
  input  logic [skf_pkg::CFG_WIDTH-1:0]       cfg_wdata_i
);

  localparam int DW     = skf_pkg::DATA_WIDTH;
  localparam int FB     = skf_pkg::FRAC_BITS;
  localparam int WIDE_W = skf_pkg::WIDE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DIV_GO,
    ST_DIV_RUN,
    ST_MUL_RUN,
    ST_FINISH
  } state_e;

  state_e                     state_q;
  logic [skf_pkg::CFG_WIDTH-1:0] q_noise_q;
  logic [skf_pkg::CFG_WIDTH-1:0] r_noise_q;
  logic [DW-1:0]              est_q;
  logic [DW-1:0]              var_q;
  logic [DW-1:0]              z_q;
  logic [DW-1:0]              ppred_q;
  logic [DW:0]                diff_q;
  logic [DW:0]                mag_q;
  logic [FB:0]                k_q;
  skf_pkg::out_beat_t         res_q;
  logic                       out_valid_q;
  skf_pkg::out_beat_t         out_data_q;

  logic [WIDE_W-1:0] pred_sum;
  logic [DW-1:0]     ppred_d;
  logic [DW:0]       diff_d;
  logic [DW:0]       mag_d;
  logic [WIDE_W-1:0] den;
  logic              div_start;
  logic              div_done;
  logic [FB:0]       div_quo;
  logic              mul_start;
  logic              est_done;
  logic              var_done;
  logic [DW:0]       delta;
  logic [DW-1:0]     var_prod;
  logic [DW-1:0]     est_new;
  logic              in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  // Predicted variance saturates at the top of the data range.
  assign pred_sum = WIDE_W'(var_q) + WIDE_W'(q_noise_q);
  assign ppred_d  = (|pred_sum[WIDE_W-1:DW]) ? '1 : pred_sum[DW-1:0];
  assign diff_d   = {z_q[DW-1], z_q} - {est_q[DW-1], est_q};
  assign mag_d    = diff_q[DW] ? (~diff_q + (DW+1)'(1)) : diff_q;
  assign den      = WIDE_W'(ppred_q) + WIDE_W'(r_noise_q);

  assign div_start = state_q == ST_DIV_GO;
  assign mul_start = (state_q == ST_DIV_RUN) && div_done;

  skf_div #(
    .NUM_W     (DW),
    .DEN_W     (WIDE_W),
    .FRAC_BITS (FB)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (ppred_q),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  skf_mul #(
    .MAG_W     (DW + 1),
    .FRAC_BITS (FB)
  ) u_mul_est (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mag_i   (mag_q),
    .k_i     (div_quo),
    .done_o  (est_done),
    .prod_o  (delta)
  );

  skf_mul #(
    .MAG_W     (DW),
    .FRAC_BITS (FB)
  ) u_mul_var (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mag_i   (ppred_q),
    .k_i     (skf_pkg::GAIN_ONE - div_quo),
    .done_o  (var_done),
    .prod_o  (var_prod)
  );

  // Move towards the measurement; the step never overshoots it.
  assign est_new = diff_q[DW] ? (est_q - delta[DW-1:0]) : (est_q + delta[DW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise_q <= skf_pkg::NOISE_RESET;
      r_noise_q <= skf_pkg::NOISE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        skf_pkg::REG_PROCESS_NOISE: q_noise_q <= cfg_wdata_i;
        skf_pkg::REG_MEASURE_NOISE: r_noise_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      est_q       <= skf_pkg::ONE_DATA;
      var_q       <= skf_pkg::ONE_DATA;
      z_q         <= '0;
      ppred_q     <= '0;
      diff_q      <= '0;
      mag_q       <= '0;
      k_q         <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            z_q <= in_data_i.measurement;
            if (in_data_i.mode) begin
              est_q          <= skf_pkg::ONE_DATA;
              var_q          <= skf_pkg::ONE_DATA;
              res_q.estimate <= skf_pkg::ONE_DATA;
              res_q.gain     <= '0;
              state_q        <= ST_FINISH;
            end else begin
              state_q <= ST_PRED;
            end
          end
        end
        ST_PRED: begin
          ppred_q <= ppred_d;
          diff_q  <= diff_d;
          state_q <= ST_DIV_GO;
        end
        ST_DIV_GO: begin
          mag_q   <= mag_d;
          state_q <= ST_DIV_RUN;
        end
        ST_DIV_RUN: begin
          if (div_done) begin
            k_q     <= div_quo;
            state_q <= ST_MUL_RUN;
          end
        end
        ST_MUL_RUN: begin
          if (est_done) begin
            est_q          <= est_new;
            var_q          <= var_prod;
            res_q.estimate <= est_new;
            res_q.gain     <= k_q;
            state_q        <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Hold the result until the output register is free.
          if (!out_valid_q || out_ready_i) begin
            out_data_q  <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SKF_ASSERT_SAME(a_mul_lockstep, 1'b1, est_done == var_done, "multipliers out of step")
  `SKF_ASSERT_SAME(a_div_done_phase, div_done, state_q == ST_DIV_RUN, "stray divider done")
  `SKF_ASSERT_NEXT(a_restart_fast, in_fire && in_data_i.mode, state_q == ST_FINISH, "slow restart")
  `SKF_ASSERT_SAME(a_gain_bound, out_valid_o, out_data_o.gain <= skf_pkg::GAIN_ONE, "gain above one")

endmodule

FILE: tb/scalar_kalman_filter_core_tb.sv
// Self-checking testbench of the scalar Kalman filter core: random beats against a predictor.
module scalar_kalman_filter_core_tb;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE_CYCLES = 2 * skf_pkg::FRAC_BITS + 12;
  localparam logic [skf_pkg::CFG_WIDTH-1:0] NOISE_MAX = '1;
  localparam logic [skf_pkg::DATA_WIDTH-1:0] DATA_MAX = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  skf_pkg::in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  skf_pkg::out_beat_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [skf_pkg::CFG_IDX_W-1:0] cfg_addr_i = skf_pkg::REG_PROCESS_NOISE;
  logic [skf_pkg::CFG_WIDTH-1:0] cfg_wdata_i = '0;

  scalar_kalman_filter_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Filter state and noise settings as the block should hold them.
  logic signed [skf_pkg::DATA_WIDTH-1:0] est_q = skf_pkg::ONE_DATA;
  logic [skf_pkg::DATA_WIDTH-1:0] var_q = skf_pkg::ONE_DATA;
  logic [skf_pkg::CFG_WIDTH-1:0] q_noise = skf_pkg::NOISE_RESET;
  logic [skf_pkg::CFG_WIDTH-1:0] r_noise = skf_pkg::NOISE_RESET;

  skf_pkg::in_beat_t pending_meas[$];
  skf_pkg::out_beat_t expected_est[$];

  bit idle_on = 1'b1;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned errors = 0;
  int unsigned beats_checked = 0;
  int unsigned restarts = 0;
  int unsigned settings = 0;
  int unsigned cycle_cnt = 0;

  // Advance the filter by one beat and return the estimate beat it should give.
  function automatic skf_pkg::out_beat_t filter_step(skf_pkg::in_beat_t beat);
    longint unsigned p_pred, den, k, mag, delta;
    longint signed x, z, diff, x_new;
    skf_pkg::out_beat_t res;
    if (beat.mode) begin
      est_q = skf_pkg::ONE_DATA;
      var_q = skf_pkg::ONE_DATA;
      res.estimate = skf_pkg::ONE_DATA;
      res.gain = '0;
      return res;
    end
    p_pred = 64'(var_q) + 64'(q_noise);
    if (p_pred > 64'(DATA_MAX)) p_pred = 64'(DATA_MAX);
    den = p_pred + 64'(r_noise);
    // p_pred never exceeds den, so the quotient fits Q1.FRAC_BITS
    if (den == 0) k = 64'(skf_pkg::GAIN_ONE);
    else k = (p_pred << skf_pkg::FRAC_BITS) / den;
    x = longint'(est_q);
    z = longint'($signed(beat.measurement));
    diff = z - x;
    if (diff < 0) begin
      mag = -diff;
      delta = (mag * k) >> skf_pkg::FRAC_BITS;
      x_new = x - longint'(delta);
    end else begin
      mag = diff;
      delta = (mag * k) >> skf_pkg::FRAC_BITS;
      x_new = x + longint'(delta);
    end
    est_q = x_new[skf_pkg::DATA_WIDTH-1:0];
    var_q = skf_pkg::DATA_WIDTH'((p_pred * (64'(skf_pkg::GAIN_ONE) - k)) >> skf_pkg::FRAC_BITS);
    res.estimate = est_q;
    res.gain = k[skf_pkg::FRAC_BITS:0];
    return res;
  endfunction

  // Mostly back to back, now and then a short or a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 8);
  endfunction

  function automatic logic [skf_pkg::CFG_WIDTH-1:0] pick_noise();
    case ($urandom_range(5))
      0: return '0;
      1: return NOISE_MAX;
      2: return skf_pkg::NOISE_RESET;
      3: return skf_pkg::CFG_WIDTH'($urandom_range(1 << 18, 1));
      default: return skf_pkg::CFG_WIDTH'($urandom);
    endcase
  endfunction

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Driver: hold each beat until taken, predict it on acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) expected_est.push_back(filter_step(in_data_i));
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_meas.size() > 0) begin
          in_data_i <= pending_meas.pop_front();
          in_valid_i <= 1'b1;
          send_gap <= idle_on ? pick_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each estimate beat against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_est.size() == 0) begin
          $error("unexpected beat: estimate %0d, gain %0d",
                 $signed(out_data_o.estimate), out_data_o.gain);
          errors++;
        end else begin
          skf_pkg::out_beat_t exp_beat;
          exp_beat = expected_est.pop_front();
          beats_checked <= beats_checked + 1;
          if (out_data_o.estimate !== exp_beat.estimate) begin
            $error("estimate: expected %0d, got %0d",
                   $signed(exp_beat.estimate), $signed(out_data_o.estimate));
            errors++;
          end
          if (out_data_o.gain !== exp_beat.gain) begin
            $error("gain: expected %0d, got %0d", exp_beat.gain, out_data_o.gain);
            errors++;
          end
        end
      end
      if (!idle_on) begin
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("scalar_kalman_filter_core: mismatch");
      $finish;
    end
  end

  task automatic write_noise(logic [skf_pkg::CFG_IDX_W-1:0] idx,
                             logic [skf_pkg::CFG_WIDTH-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    if (idx == skf_pkg::REG_PROCESS_NOISE) q_noise = val;
    else r_noise = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_noise(logic [skf_pkg::CFG_WIDTH-1:0] q, logic [skf_pkg::CFG_WIDTH-1:0] r);
    write_noise(skf_pkg::REG_PROCESS_NOISE, q);
    write_noise(skf_pkg::REG_MEASURE_NOISE, r);
    settings++;
    @(negedge clk_i);
  endtask

  task automatic queue_meas(logic mode, logic [skf_pkg::DATA_WIDTH-1:0] z);
    skf_pkg::in_beat_t beat;
    beat.mode = mode;
    beat.measurement = z;
    if (mode) restarts++;
    pending_meas.push_back(beat);
  endtask

  // Wait until every beat has been sent and every estimate has come back.
  task automatic drain();
    while (pending_meas.size() > 0 || in_valid_i || expected_est.size() > 0)
      @(negedge clk_i);
  endtask

  initial begin
    logic [skf_pkg::DATA_WIDTH-1:0] target;
    int unsigned r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset noise: extremes of the measurement, restarts with junk measurements
    queue_meas(1'b0, '0);
    queue_meas(1'b0, 32'h7FFF_FFFF);
    queue_meas(1'b0, 32'h8000_0000);
    queue_meas(1'b0, 32'h7FFF_FFFF);
    queue_meas(1'b1, 32'hFFFF_FFFF);
    queue_meas(1'b0, 32'hFFFF_FFFF);
    queue_meas(1'b0, 32'h0001_0000);
    queue_meas(1'b1, '0);
    drain();

    // No noise at all: gain one, variance drops to zero, then a zero divisor
    set_noise('0, '0);
    queue_meas(1'b0, 32'h1234_5678);
    queue_meas(1'b0, 32'h8000_0000);
    queue_meas(1'b0, 32'h7FFF_FFFF);
    queue_meas(1'b1, 32'h5A5A_5A5A);
    queue_meas(1'b0, 32'hFFFF_FFFF);
    drain();

    // Largest noise: predicted variance saturates
    set_noise(NOISE_MAX, NOISE_MAX);
    queue_meas(1'b0, 32'h7FFF_FFFF);
    queue_meas(1'b0, 32'h8000_0000);
    queue_meas(1'b0, '0);
    queue_meas(1'b0, 32'h0000_1234);
    drain();

    set_noise(NOISE_MAX, '0);
    queue_meas(1'b0, 32'h8000_0000);
    queue_meas(1'b0, 32'h7FFF_FFFF);
    drain();

    set_noise('0, NOISE_MAX);
    queue_meas(1'b0, 32'h7FFF_FFFF);
    queue_meas(1'b0, 32'h8000_0000);
    queue_meas(1'b0, '0);
    drain();

    // Tracked signal with noise, plus wild values and restarts
    for (int ph = 0; ph < 6; ph++) begin
      set_noise(pick_noise(), pick_noise());
      idle_on = (ph != 2);
      target = $urandom;
      for (int n = 0; n < 125; n++) begin
        if (n % 20 == 0) target = $urandom;
        r = $urandom_range(99);
        if (r < 8) queue_meas(1'b1, $urandom);
        else if (r < 13) queue_meas(1'b0, $urandom);
        else if (r < 18) begin
          case ($urandom_range(3))
            0: queue_meas(1'b0, 32'h7FFF_FFFF);
            1: queue_meas(1'b0, 32'h8000_0000);
            2: queue_meas(1'b0, '0);
            default: queue_meas(1'b0, '1);
          endcase
        end else queue_meas(1'b0, target + $urandom_range(1 << 12) - (1 << 11));
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_est.size() != 0) begin
      $error("%0d estimate beats never arrived", expected_est.size());
      errors++;
    end
    $display("%0d estimate beats checked, %0d of them restarts, over %0d noise settings",
             beats_checked, restarts, settings + 1);
    $display("settings included zero and full-scale noise, zero divisor and saturation");
    if (errors == 0) begin
      $display("scalar_kalman_filter_core: match");
    end else begin
      $display("scalar_kalman_filter_core: mismatch");
    end
    $finish;
  end

endmodule
